/* rtl/sht_pkg.sv */
package sht_pkg;

    localparam int ADDR_W       = 48;
    localparam int SEL_W        = 8;
    localparam int DEF_ENTRIES  = 16;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_GET_KEY  = 3'd1;
    localparam logic [2:0] OP_GET_ID   = 3'd2;
    localparam logic [2:0] OP_GET_ADDR = 3'd3;
    localparam logic [2:0] OP_UPDATE   = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [1:0] CMT_NONE    = 2'd0;
    localparam logic [1:0] CMT_ALLOC   = 2'd1;
    localparam logic [1:0] CMT_CLEAR   = 2'd2;
    localparam logic [1:0] CMT_UPDATE  = 2'd3;

    typedef struct packed {
        logic [2:0]        opcode;
        logic              delete_after;
        logic signed [31:0] lookup_value;
        logic [ADDR_W-1:0] address;
        logic signed [31:0] new_segment_id;
        logic [31:0]       new_size;
        logic [SEL_W-1:0]  entry_select;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        hit_index;
        logic              hit_in_use;
        logic signed [31:0] hit_key;
        logic signed [31:0] hit_segment_id;
        logic [ADDR_W-1:0] hit_address;
        logic [31:0]       hit_size;
        logic [4:0]        used_count;
    } rsp_t;

    // request word travelling down the row, gathering match results
    typedef struct packed {
        logic              valid;
        req_t              req;
        logic              conflict;
        logic              k_found;
        logic              s_found;
        logic              a_found;
        logic              ff_found;
        logic [SEL_W-1:0]  ff_idx;
        logic [31:0]       ff_id;
        logic [ADDR_W-1:0] ff_addr;
        logic [31:0]       ff_size;
        logic              cap_found;
        logic [SEL_W-1:0]  cap_idx;
        logic              cap_used;
        logic [31:0]       cap_key;
        logic [31:0]       cap_id;
        logic [ADDR_W-1:0] cap_addr;
        logic [31:0]       cap_size;
    } token_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SEL_W-1:0]  idx;
        logic [31:0]       key;
        logic [31:0]       id;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       size;
    } commit_t;

endpackage

/* rtl/sht_stream_if.sv */
interface sht_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sht_cell.sv */
module sht_cell #(
    parameter logic [sht_pkg::SEL_W-1:0] CELL_INDEX = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sht_pkg::token_t  tok_in,
    output sht_pkg::token_t  tok_out,
    input  sht_pkg::commit_t commit
);
    import sht_pkg::*;

    logic              used_reg;
    logic [31:0]       key_reg;
    logic [31:0]       id_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       size_reg;

    token_t tok_reg;
    token_t tok_next;
    logic   tok_valid_reg;

    logic match_k;
    logic match_s;
    logic match_a;
    logic take;

    always_comb
    begin
        match_k = (tok_in.req.lookup_value != '0) && (key_reg == tok_in.req.lookup_value);
        match_s = (tok_in.req.lookup_value != '0) && (id_reg == tok_in.req.lookup_value);
        match_a = (tok_in.req.address != '0) && (addr_reg == tok_in.req.address);

        case (tok_in.req.opcode)
            OP_CREATE, OP_GET_KEY: take = match_k;
            OP_GET_ID:             take = match_s;
            OP_GET_ADDR:           take = match_a;
            OP_UPDATE, OP_READ:    take = (tok_in.req.entry_select == CELL_INDEX);
            default:               take = 1'b0;
        endcase

        tok_next = tok_in;
        tok_next.conflict = tok_in.conflict | (match_k & tok_in.k_found)
                          | (match_s & tok_in.s_found) | (match_a & tok_in.a_found);
        tok_next.k_found = tok_in.k_found | match_k;
        tok_next.s_found = tok_in.s_found | match_s;
        tok_next.a_found = tok_in.a_found | match_a;

        if (!tok_in.ff_found && !used_reg)
        begin
            tok_next.ff_found = 1'b1;
            tok_next.ff_idx   = CELL_INDEX;
            tok_next.ff_id    = id_reg;
            tok_next.ff_addr  = addr_reg;
            tok_next.ff_size  = size_reg;
        end

        if (take)
        begin
            tok_next.cap_found = 1'b1;
            tok_next.cap_idx   = CELL_INDEX;
            tok_next.cap_used  = used_reg;
            tok_next.cap_key   = key_reg;
            tok_next.cap_id    = id_reg;
            tok_next.cap_addr  = addr_reg;
            tok_next.cap_size  = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_next.valid)
        begin
            tok_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    // entry contents, written only by the decision stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            key_reg  <= '0;
            id_reg   <= '0;
            addr_reg <= '0;
            size_reg <= '0;
        end
        else if (commit.idx == CELL_INDEX)
        begin
            case (commit.kind)
                CMT_ALLOC:
                begin
                    used_reg <= 1'b1;
                    key_reg  <= commit.key;
                end
                CMT_CLEAR:
                begin
                    used_reg <= 1'b0;
                    key_reg  <= '0;
                    id_reg   <= '0;
                    addr_reg <= '0;
                    size_reg <= '0;
                end
                CMT_UPDATE:
                begin
                    id_reg   <= commit.id;
                    addr_reg <= commit.addr;
                    size_reg <= commit.size;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

/* rtl/segment_handle_table_core.sv */
// one request at a time: it walks the row of entry cells, one cell per cycle
// a new request is taken only once the previous one's result has been decided into the result register
// the result register holds a finished word while the next request runs
// asynchronous active-low reset empties every entry and zeroes the used count
module segment_handle_table_core #(
    parameter int TABLE_ENTRIES = sht_pkg::DEF_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    sht_stream_if.sink   req,
    sht_stream_if.source rsp
);
    import sht_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [SEL_W:0] ENTRIES_W = (SEL_W + 1)'(TABLE_ENTRIES);

    token_t  chain [TABLE_ENTRIES+1];
    token_t  first_tok;
    token_t  done_reg;
    logic    done_valid_reg;
    logic    busy_reg;
    logic    out_valid_reg;
    rsp_t    out_reg;
    rsp_t    out_next;
    commit_t commit;
    logic    [CNT_W-1:0] count_reg;
    logic    [CNT_W-1:0] count_next;
    logic    accept;
    logic    decide;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign decide    = done_valid_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        first_tok       = '0;
        first_tok.valid = accept;
        first_tok.req   = req.data;
    end

    assign chain[0] = first_tok;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        sht_cell #(
            .CELL_INDEX (SEL_W'(i))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .commit  (commit)
        );
    end

    always_comb
    begin
        out_next            = '0;
        commit              = '0;
        commit.kind         = CMT_NONE;
        count_next          = count_reg;

        case (done_reg.req.opcode)
            OP_CREATE, OP_GET_KEY, OP_GET_ID, OP_GET_ADDR:
            begin
                if (done_reg.conflict)
                begin
                    out_next.status = ST_CONFLICT;
                end
                else if (done_reg.cap_found)
                begin
                    out_next.status         = ST_OK;
                    out_next.hit_index      = 4'(done_reg.cap_idx);
                    out_next.hit_in_use     = done_reg.cap_used;
                    out_next.hit_key        = done_reg.cap_key;
                    out_next.hit_segment_id = done_reg.cap_id;
                    out_next.hit_address    = done_reg.cap_addr;
                    out_next.hit_size       = done_reg.cap_size;
                    commit.idx              = done_reg.cap_idx;
                    if (done_reg.req.delete_after)
                    begin
                        commit.kind = CMT_CLEAR;
                        if (done_reg.cap_used)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                else if (done_reg.req.opcode == OP_CREATE && done_reg.ff_found)
                begin
                    out_next.status         = ST_OK;
                    out_next.hit_index      = 4'(done_reg.ff_idx);
                    out_next.hit_in_use     = 1'b1;
                    out_next.hit_key        = done_reg.req.lookup_value;
                    out_next.hit_segment_id = done_reg.ff_id;
                    out_next.hit_address    = done_reg.ff_addr;
                    out_next.hit_size       = done_reg.ff_size;
                    commit.idx              = done_reg.ff_idx;
                    commit.key              = done_reg.req.lookup_value;
                    // allocate and delete at once leaves the count as it was
                    if (done_reg.req.delete_after)
                    begin
                        commit.kind = CMT_CLEAR;
                    end
                    else
                    begin
                        commit.kind = CMT_ALLOC;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    out_next.status = ST_MISS;
                end
            end
            OP_UPDATE, OP_READ:
            begin
                if ({1'b0, done_reg.req.entry_select} >= ENTRIES_W)
                begin
                    out_next.status   = ST_RANGE;
                    out_next.hit_size = 32'(TABLE_ENTRIES);
                end
                else
                begin
                    out_next.status         = ST_OK;
                    out_next.hit_index      = 4'(done_reg.req.entry_select);
                    out_next.hit_in_use     = done_reg.cap_used;
                    out_next.hit_key        = done_reg.cap_key;
                    out_next.hit_segment_id = done_reg.cap_id;
                    out_next.hit_address    = done_reg.cap_addr;
                    out_next.hit_size       = done_reg.cap_size;
                    if (done_reg.req.opcode == OP_UPDATE)
                    begin
                        out_next.hit_segment_id = done_reg.req.new_segment_id;
                        out_next.hit_address    = done_reg.req.address;
                        out_next.hit_size       = done_reg.req.new_size;
                        commit.kind             = CMT_UPDATE;
                        commit.idx              = done_reg.req.entry_select;
                        commit.id               = done_reg.req.new_segment_id;
                        commit.addr             = done_reg.req.address;
                        commit.size             = done_reg.req.new_size;
                    end
                end
            end
            default:
            begin
                out_next.status = ST_MISS;
            end
        endcase

        out_next.used_count = 5'(count_next);

        if (!decide)
        begin
            commit.kind = CMT_NONE;
            count_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (decide)
            begin
                busy_reg <= 1'b0;
            end

            if (chain[TABLE_ENTRIES].valid)
            begin
                done_valid_reg <= 1'b1;
            end
            else if (decide)
            begin
                done_valid_reg <= 1'b0;
            end

            if (decide)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[TABLE_ENTRIES].valid)
        begin
            done_reg <= chain[TABLE_ENTRIES];
        end
        if (decide)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule

/* test/testbench.sv */
module testbench;
    import sht_pkg::*;

    localparam int NUM_SLOTS   = DEF_ENTRIES;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;

    // opcodes with no meaning in the block
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        req_t word;
        bit   pinned;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sht_stream_if #(.T(req_t)) req_if ();
    sht_stream_if #(.T(rsp_t)) rsp_if ();

    segment_handle_table_core #(.TABLE_ENTRIES(NUM_SLOTS)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // shadow copy of the table
    logic              tbl_used [NUM_SLOTS];
    logic [31:0]       tbl_key  [NUM_SLOTS];
    logic [31:0]       tbl_id   [NUM_SLOTS];
    logic [ADDR_W-1:0] tbl_addr [NUM_SLOTS];
    logic [31:0]       tbl_size [NUM_SLOTS];
    logic [4:0]        tbl_live;

    rsp_t     pending_rsp [$];
    dir_row_t dir_rows [$];

    bit   pin_flag = 1'b0;
    rsp_t pin_word = '0;

    int send_idle_pct = 20;
    int recv_idle_pct = 51;

    int mismatches  = 0;
    int idle_cycles = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_full      = 0;
    int n_conflict  = 0;
    int n_range     = 0;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic cmp_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic rsp_t slot_view(int idx);
        rsp_t o;
        o = '0;
        o.status         = ST_OK;
        o.hit_index      = idx[3:0];
        o.hit_in_use     = tbl_used[idx];
        o.hit_key        = tbl_key[idx];
        o.hit_segment_id = tbl_id[idx];
        o.hit_address    = tbl_addr[idx];
        o.hit_size       = tbl_size[idx];
        return o;
    endfunction

    function automatic rsp_t table_predict(req_t r);
        rsp_t        o;
        int          first_free;
        int          k_hit;
        int          s_hit;
        int          a_hit;
        int          hit;
        bit          conflict;
        logic [31:0] v;
        int          sel;
        o = '0;
        v = r.lookup_value;
        sel = r.entry_select;
        first_free = -1;
        k_hit = -1;
        s_hit = -1;
        a_hit = -1;
        hit = -1;
        conflict = 1'b0;
        if (r.opcode <= OP_GET_ADDR) begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (first_free < 0 && !tbl_used[i])
                    first_free = i;
                if (v != 0) begin
                    if (tbl_key[i] == v)
                    begin
                        if (k_hit >= 0)
                            conflict = 1'b1;
                        k_hit = i;
                    end
                    if (tbl_id[i] == v)
                    begin
                        if (s_hit >= 0)
                            conflict = 1'b1;
                        s_hit = i;
                    end
                end
                if (r.address != 0 && tbl_addr[i] == r.address)
                begin
                    if (a_hit >= 0)
                        conflict = 1'b1;
                    a_hit = i;
                end
            end
            if (conflict)
                o.status = ST_CONFLICT;
            else
            begin
                case (r.opcode)
                    OP_CREATE:
                    begin
                        if (k_hit >= 0)
                            hit = k_hit;
                        else if (first_free >= 0)
                        begin
                            hit = first_free;
                            tbl_used[hit] = 1'b1;
                            tbl_key[hit] = v;
                            tbl_live++;
                        end
                    end
                    OP_GET_KEY: hit = k_hit;
                    OP_GET_ID:  hit = s_hit;
                    default:    hit = a_hit;
                endcase
                if (hit < 0)
                    o.status = ST_MISS;
                else
                begin
                    o = slot_view(hit);
                    if (r.delete_after)
                    begin
                        // count only drops for a slot that was really in use
                        if (tbl_used[hit] && tbl_live > 0)
                            tbl_live--;
                        tbl_used[hit] = 1'b0;
                        tbl_key[hit] = '0;
                        tbl_id[hit] = '0;
                        tbl_addr[hit] = '0;
                        tbl_size[hit] = '0;
                    end
                end
            end
        end
        else if (r.opcode == OP_UPDATE || r.opcode == OP_READ)
        begin
            if (sel >= NUM_SLOTS)
            begin
                o.status = ST_RANGE;
                o.hit_size = NUM_SLOTS;
            end
            else
            begin
                if (r.opcode == OP_UPDATE)
                begin
                    tbl_id[sel] = r.new_segment_id;
                    tbl_addr[sel] = r.address;
                    tbl_size[sel] = r.new_size;
                end
                o = slot_view(sel);
            end
        end
        else
            o.status = ST_MISS;
        o.used_count = tbl_live;
        return o;
    endfunction

    function automatic req_t mk_req(logic [2:0] op, logic del, logic [31:0] val,
                                    logic [ADDR_W-1:0] addr, logic [31:0] id,
                                    logic [31:0] size, logic [SEL_W-1:0] sel);
        req_t r;
        r.opcode         = op;
        r.delete_after   = del;
        r.lookup_value   = val;
        r.address        = addr;
        r.new_segment_id = id;
        r.new_size       = size;
        r.entry_select   = sel;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [1:0] st, logic [3:0] idx, logic used,
                                    logic [31:0] key, logic [31:0] id,
                                    logic [ADDR_W-1:0] addr, logic [31:0] size,
                                    logic [4:0] cnt);
        rsp_t o;
        o.status         = st;
        o.hit_index      = idx;
        o.hit_in_use     = used;
        o.hit_key        = key;
        o.hit_segment_id = id;
        o.hit_address    = addr;
        o.hit_size       = size;
        o.used_count     = cnt;
        return o;
    endfunction

    task automatic add_row(req_t w, bit pinned, rsp_t want);
        dir_row_t row;
        row.word = w;
        row.pinned = pinned;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // small pools so that keys, ids and addresses collide often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3, 4, 5: return $urandom_range(1, 24);
            6:       return 32'hFFFF_FFFF - $urandom_range(2);
            7:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1:    return '0;
            2, 3, 4, 5: return $urandom_range(1, 24);
            6:       return {ADDR_W{1'b1}} - $urandom_range(2);
            7:       return {1'b1, {(ADDR_W-1){1'b0}}};
            default: return wide[ADDR_W-1:0];
        endcase
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 28)
            r.opcode = OP_CREATE;
        else if (pick < 43)
            r.opcode = OP_GET_KEY;
        else if (pick < 53)
            r.opcode = OP_GET_ID;
        else if (pick < 63)
            r.opcode = OP_GET_ADDR;
        else if (pick < 77)
            r.opcode = OP_UPDATE;
        else if (pick < 95)
            r.opcode = OP_READ;
        else
            r.opcode = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        r.delete_after   = ($urandom_range(99) < 30);
        r.lookup_value   = pick_value();
        r.address        = pick_addr();
        r.new_segment_id = ($urandom_range(99) < 40) ? 32'h0 : pick_value();
        r.new_size       = $urandom;
        r.entry_select   = ($urandom_range(9) == 0) ? SEL_W'($urandom_range(255))
                                                    : SEL_W'($urandom_range(NUM_SLOTS - 1));
        return r;
    endfunction

    task automatic send_word(req_t w, bit pinned, rsp_t want);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 24);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        pin_flag     <= pinned;
        pin_word     <= want;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // response checking, prediction on accept, receiver stalls
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        rsp_t pred;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (pending_rsp.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    want = pending_rsp.pop_front();
                    cmp_field("status", got.status, want.status);
                    cmp_field("hit_index", got.hit_index, want.hit_index);
                    cmp_field("hit_in_use", got.hit_in_use, want.hit_in_use);
                    cmp_field("hit_key", got.hit_key, want.hit_key);
                    cmp_field("hit_segment_id", got.hit_segment_id, want.hit_segment_id);
                    cmp_field("hit_address", got.hit_address, want.hit_address);
                    cmp_field("hit_size", got.hit_size, want.hit_size);
                    cmp_field("used_count", got.used_count, want.used_count);
                end
                n_checked++;
            end
            if (req_if.valid && req_if.ready)
            begin
                pred = table_predict(req_if.data);
                if (req_if.data.opcode == OP_CREATE && pred.status == ST_MISS)
                    n_full++;
                if (pred.status == ST_CONFLICT)
                    n_conflict++;
                if (pred.status == ST_RANGE)
                    n_range++;
                pending_rsp.push_back(pin_flag ? pin_word : pred);
                n_sent++;
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
            tbl_id[i]   = '0;
            tbl_addr[i] = '0;
            tbl_size[i] = '0;
        end
        tbl_live = '0;

        // directed rows: reset contents, range errors, allocation order, reuse,
        // zero key, extreme values, conflicts, stray opcodes, delete of a free slot
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_OK, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 8'hFF), 1,
                mk_rsp(ST_RANGE, 0, 0, 0, 0, 0, NUM_SLOTS, 0));
        add_row(mk_req(OP_UPDATE, 0, 0, 48'h1, 32'h1, 32'h1, NUM_SLOTS), 1,
                mk_rsp(ST_RANGE, 0, 0, 0, 0, 0, NUM_SLOTS, 0));
        add_row(mk_req(OP_GET_KEY, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_MISS, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_GET_ADDR, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_MISS, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_CREATE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0), 1,
                mk_rsp(ST_OK, 0, 1, 32'h7FFF_FFFF, 0, 0, 0, 1));
        add_row(mk_req(OP_CREATE, 0, 32'h8000_0000, 0, 0, 0, 0), 1,
                mk_rsp(ST_OK, 1, 1, 32'h8000_0000, 0, 0, 0, 2));
        add_row(mk_req(OP_CREATE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0), 1,
                mk_rsp(ST_OK, 0, 1, 32'h7FFF_FFFF, 0, 0, 0, 2));
        add_row(mk_req(OP_CREATE, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_OK, 2, 1, 0, 0, 0, 0, 3));
        add_row(mk_req(OP_UPDATE, 0, 0, {ADDR_W{1'b1}}, 32'h8000_0000, 32'hFFFF_FFFF, 0), 1,
                mk_rsp(ST_OK, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, {ADDR_W{1'b1}},
                       32'hFFFF_FFFF, 3));
        add_row(mk_req(OP_UPDATE, 0, 0, 48'h1, 32'h5, 32'h0, NUM_SLOTS - 1), 0, '0);
        add_row(mk_req(OP_GET_ID, 0, 32'h8000_0000, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_GET_ADDR, 0, 0, {ADDR_W{1'b1}}, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_GET_KEY, 1, 32'h8000_0000, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 1), 0, '0);
        add_row(mk_req(OP_CREATE, 0, 32'h1234, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_UPDATE, 0, 0, 48'h2, 32'h5, 32'h7, 1), 0, '0);
        add_row(mk_req(OP_GET_ID, 0, 32'h5, 0, 0, 0, 0), 1,
                mk_rsp(ST_CONFLICT, 0, 0, 0, 0, 0, 0, 3));
        add_row(mk_req(OP_SPARE_6, 0, 32'h7FFF_FFFF, 0, 0, 0, 0), 1,
                mk_rsp(ST_MISS, 0, 0, 0, 0, 0, 0, 3));
        add_row(mk_req(OP_SPARE_7, 1, 32'h1234, 48'h2, 0, 0, 1), 1,
                mk_rsp(ST_MISS, 0, 0, 0, 0, 0, 0, 3));
        add_row(mk_req(OP_GET_ADDR, 1, 0, 48'h1, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_READ, 1, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_UPDATE, 1, 0, 48'h3, 32'h9, 32'h8000_0000, 2), 0, '0);
        add_row(mk_req(OP_GET_KEY, 1, 32'h7FFF_FFFF, 0, 0, 0, 0), 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (176)
                send_word(random_request(), 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests sent, %0d result words checked, %0d mismatches",
                 n_sent, n_checked, mismatches);
        $display("seen: %0d creates on a full table, %0d conflicts, %0d index errors",
                 n_full, n_conflict, n_range);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
